>>> rtl/core/lfht_pkg.sv
// lfht_pkg: shared constants, opcode and status codes, and the
// controller/datapath command and status structs of the handle table
// no dependencies
package lfht_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = $clog2(SLOTS);

    // free-slot search covers one group of the used mask per cycle
    localparam int GROUP   = (SLOTS < 16) ? SLOTS : 16;
    localparam int NGROUPS = (SLOTS + GROUP - 1) / GROUP;
    localparam int GRP_W   = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    localparam int POS_W   = $clog2(GROUP);
    localparam int PAD_N   = NGROUPS * GROUP;

    localparam logic [2:0] OP_OPEN_FILE      = 3'd0;
    localparam logic [2:0] OP_INSTALL_SOCKET = 3'd1;
    localparam logic [2:0] OP_CLOSE_FILE     = 3'd2;
    localparam logic [2:0] OP_CLOSE_SOCKET   = 3'd3;
    localparam logic [2:0] OP_GET_SOCKET     = 3'd4;
    localparam logic [2:0] OP_EXISTS         = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic        is_socket;
        logic [2:0]  node;
        logic [31:0] handle;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic capture;
        logic search;
        logic grant;
        logic eval;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic is_open;
        logic hit;
        logic last_group;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/core/lfht_ram.sv
// lfht_ram: generic single-write, single-read ram with registered read data
// no dependencies
module lfht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/lfht_ctrl.sv
// lfht_ctrl: sequencing state machine of the handle table
// depends on lfht_pkg for the command and status structs
module lfht_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lfht_pkg::dp_stat_t stat,
    output lfht_pkg::dp_cmd_t  cmd
);
    import lfht_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_GRANT  = 3'd3;
    localparam logic [2:0] S_EVAL   = 3'd4;
    localparam logic [2:0] S_POST   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            // ram address settles from the captured slot here
            S_READ:
            begin
                state_next = stat.is_open ? S_SEARCH : S_EVAL;
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                if (stat.hit || stat.last_group)
                begin
                    state_next = S_GRANT;
                end
            end
            S_GRANT:
            begin
                cmd.grant  = 1'b1;
                state_next = S_POST;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_POST;
            end
            S_POST:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/lfht_dp.sv
// lfht_dp: item registers, used mask, free-slot search, entry ram and
// result/output registers of the handle table
// depends on lfht_pkg and lfht_ram
module lfht_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         opcode,
    input  logic [7:0]         slot_in,
    input  logic [2:0]         node_index,
    input  logic [31:0]        socket_handle,
    input  lfht_pkg::dp_cmd_t  cmd,
    output lfht_pkg::dp_stat_t stat,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [3:0]         slot_out,
    output logic [31:0]        handle_out
);
    import lfht_pkg::*;

    logic [2:0]       op_reg;
    logic [7:0]       slot_reg;
    logic [2:0]       node_reg;
    logic [31:0]      handle_reg;
    logic [SLOTS-1:0] used_reg;
    logic [SLOTS-1:0] used_next;
    logic [GRP_W-1:0] group_reg;
    logic             found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [1:0]       res_status_reg;
    logic [3:0]       res_slot_reg;
    logic [31:0]      res_handle_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [1:0]       status_reg;
    logic [3:0]       slot_out_reg;
    logic [31:0]      handle_out_reg;

    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             slot_busy;
    logic             live;
    logic [PAD_N-1:0] used_pad;
    logic [GROUP-1:0] grp_bits;
    logic             hit;
    logic [POS_W-1:0] pos;
    logic [IDX_W-1:0] cand_idx;
    logic [1:0]       eval_status;
    logic [31:0]      eval_handle;
    logic             clear_en;
    entry_t           wr_entry;
    entry_t           rd_entry;
    logic [ENTRY_W-1:0] rd_word;

    assign idx       = slot_reg[IDX_W-1:0];
    assign in_range  = {1'b0, slot_reg} < 9'(SLOTS);
    assign slot_busy = in_range && used_reg[idx];

    // slots past the end of the table read as used so the search skips them
    always_comb
    begin
        for (int i = 0; i < PAD_N; i++)
        begin
            used_pad[i] = (i < SLOTS) ? used_reg[i] : 1'b1;
        end
    end

    assign grp_bits = used_pad[group_reg * GROUP +: GROUP];

    always_comb
    begin
        hit = 1'b0;
        pos = '0;
        for (int i = GROUP - 1; i >= 0; i--)
        begin
            if (!grp_bits[i])
            begin
                hit = 1'b1;
                pos = POS_W'(i);
            end
        end
    end

    assign cand_idx = IDX_W'({group_reg, pos});

    assign stat.is_open    = (op_reg == OP_OPEN_FILE) || (op_reg == OP_INSTALL_SOCKET);
    assign stat.hit        = hit;
    assign stat.last_group = (group_reg == GRP_W'(NGROUPS - 1));
    assign stat.out_free   = !out_valid_reg || !out_stall;

    // entry store
    always_comb
    begin
        wr_entry.is_socket = (op_reg == OP_INSTALL_SOCKET);
        wr_entry.node      = (op_reg == OP_OPEN_FILE) ? node_reg : 3'd0;
        wr_entry.handle    = (op_reg == OP_INSTALL_SOCKET) ? handle_reg : 32'd0;
    end

    lfht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (cmd.grant && found_reg),
        .wr_addr (free_idx_reg),
        .wr_data (wr_entry),
        .rd_addr (idx),
        .rd_data (rd_word)
    );

    assign rd_entry = rd_word;

    // a socket with a zero handle counts as absent
    assign live = slot_busy && rd_entry.is_socket && (rd_entry.handle != 32'd0);

    always_comb
    begin
        eval_status = ST_BAD;
        eval_handle = 32'd0;
        clear_en    = 1'b0;
        unique case (op_reg)
            OP_CLOSE_FILE:
            begin
                if (slot_busy && !rd_entry.is_socket)
                begin
                    eval_status = ST_OK;
                    clear_en    = 1'b1;
                end
            end
            OP_CLOSE_SOCKET:
            begin
                if (live)
                begin
                    eval_status = ST_OK;
                    clear_en    = 1'b1;
                end
            end
            OP_GET_SOCKET:
            begin
                if (live)
                begin
                    eval_status = ST_OK;
                    eval_handle = rd_entry.handle;
                end
            end
            OP_EXISTS:
            begin
                if (slot_busy)
                begin
                    eval_status = ST_OK;
                end
            end
            default:
            begin
                eval_status = ST_BAD;
            end
        endcase
    end

    always_comb
    begin
        used_next = used_reg;
        if (cmd.grant && found_reg)
        begin
            used_next[free_idx_reg] = 1'b1;
        end
        if (cmd.eval && clear_en)
        begin
            used_next[idx] = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= opcode;
            slot_reg   <= slot_in;
            node_reg   <= node_index;
            handle_reg <= socket_handle;
            group_reg  <= '0;
        end
        if (cmd.search)
        begin
            found_reg    <= hit;
            free_idx_reg <= cand_idx;
            if (!hit)
            begin
                group_reg <= group_reg + GRP_W'(1);
            end
        end
        if (cmd.grant)
        begin
            res_status_reg <= found_reg ? ST_OK : ST_FULL;
            res_slot_reg   <= found_reg ? 4'(free_idx_reg) : 4'd0;
            res_handle_reg <= 32'd0;
        end
        if (cmd.eval)
        begin
            res_status_reg <= eval_status;
            res_slot_reg   <= 4'd0;
            res_handle_reg <= eval_handle;
        end
        if (cmd.load_out)
        begin
            status_reg     <= res_status_reg;
            slot_out_reg   <= res_slot_reg;
            handle_out_reg <= res_handle_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_out   = slot_out_reg;
    assign handle_out = handle_out_reg;

endmodule

>>> rtl/core/lowest_free_handle_table_unit.sv
// lowest_free_handle_table_unit: top level of the file/socket handle table
// depends on lfht_pkg, lfht_ctrl, lfht_dp (and lfht_ram through lfht_dp)
//
// usage
//   input channel: opcode, slot_in, node_index, socket_handle, taken on a beat
//   where in_valid is high and in_stall low. output channel: status, slot_out,
//   handle_out, delivered on a beat where out_valid is high and out_stall low.
//   every input beat gives exactly one output beat, in order.
// sequencing
//   one item is in flight at a time. close, get and exists pass the read and
//   eval states, opens the read, search and grant states, where the free-slot
//   search scans 16 entries of the used mask per cycle; the post state then
//   loads the output register once it is free. in_stall drops again in the
//   cycle after the result is loaded, so a new item may enter while that
//   result still waits.
// reset
//   rst_n clears the used mask (all slots free) and the output valid at once;
//   the entry ram keeps no reset, its entries are written by every open that finds a free slot.
// stall
//   while out_stall holds a result, the next finished result waits in the
//   datapath and no further item is taken.
module lowest_free_handle_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [7:0]  slot_in,
    input  logic [2:0]  node_index,
    input  logic [31:0] socket_handle,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  slot_out,
    output logic [31:0] handle_out
);
    import lfht_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lfht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    lfht_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .opcode        (opcode),
        .slot_in       (slot_in),
        .node_index    (node_index),
        .socket_handle (socket_handle),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .slot_out      (slot_out),
        .handle_out    (handle_out)
    );

endmodule

>>> rtl/core/lfht_checker.sv
// lfht_checker: port-level assertions for the handle table, bound to the top
// depends on lfht_pkg for status codes
module lfht_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [3:0]  slot_out,
    input logic [31:0] handle_out
);
    import lfht_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot_out)
            && $stable(handle_out))
        else $error("stalled result changed");

    // one item at a time: input stalls right after a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while busy");

    // only a successful get carries a handle, only a successful open a slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (handle_out != 32'd0) |-> (status == ST_OK) && (slot_out == 4'd0))
        else $error("handle on a non-get result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (slot_out == 4'd0) && (handle_out == 32'd0)
            && ((status == ST_BAD) || (status == ST_FULL)))
        else $error("failed result carries payload or bad status code");

endmodule

bind lowest_free_handle_table_unit lfht_checker u_lfht_checker (.*);

>>> dv/testbench.sv
`timescale 1ns / 100ps
// testbench for lowest_free_handle_table_unit: directed and random requests with a
// self-contained table predictor, checked beat by beat on the result channel
// depends on lfht_pkg and the rtl of the handle table
module testbench;
    import lfht_pkg::*;

    // opcodes with no defined function
    localparam logic [2:0] OP_RESERVED_6 = 3'd6;
    localparam logic [2:0] OP_RESERVED_7 = 3'd7;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 150;
    localparam int BATCH_LEN   = 64;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  slot;
        logic [2:0]  node;
        logic [31:0] handle;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [31:0] handle;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  opcode = '0;
    logic [7:0]  slot_in = '0;
    logic [2:0]  node_index = '0;
    logic [31:0] socket_handle = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic [31:0] handle_out;

    request_t request_queue[$];
    reply_t   expected_replies[$];

    // shadow of the descriptor table
    bit          slot_busy[SLOTS];
    bit          slot_sock[SLOTS];
    logic [2:0]  slot_dev[SLOTS];
    logic [31:0] slot_hnd[SLOTS];

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int replies_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;
    int zero_handles_left = 4;

    wire in_beat  = in_valid && !in_stall;
    wire out_beat = out_valid && !out_stall;

    lowest_free_handle_table_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .slot_in       (slot_in),
        .node_index    (node_index),
        .socket_handle (socket_handle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .slot_out      (slot_out),
        .handle_out    (handle_out)
    );

    always #1 clk = ~clk;

    // applies one request to the shadow table and returns the reply it gives
    function automatic reply_t apply_request(request_t rq);
        reply_t rp;
        int     free_idx;
        int     idx;
        bit     in_range;
        bit     live_sock;
        rp = '{status: ST_BAD, slot: '0, handle: '0};
        in_range = (rq.slot < SLOTS);
        idx = in_range ? int'(rq.slot) : 0;
        free_idx = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (!slot_busy[i])
                free_idx = i;
        live_sock = in_range && slot_busy[idx] && slot_sock[idx] && slot_hnd[idx] != 32'd0;
        case (rq.opcode)
            OP_OPEN_FILE, OP_INSTALL_SOCKET:
            begin
                if (free_idx < 0)
                    rp.status = ST_FULL;
                else
                begin
                    slot_busy[free_idx] = 1'b1;
                    slot_sock[free_idx] = (rq.opcode == OP_INSTALL_SOCKET);
                    slot_dev[free_idx] = (rq.opcode == OP_OPEN_FILE) ? rq.node : 3'd0;
                    slot_hnd[free_idx] = (rq.opcode == OP_INSTALL_SOCKET) ? rq.handle : 32'd0;
                    rp.status = ST_OK;
                    rp.slot = free_idx[3:0];
                end
            end
            OP_CLOSE_FILE:
            begin
                if (in_range && slot_busy[idx] && !slot_sock[idx])
                begin
                    slot_busy[idx] = 1'b0;
                    rp.status = ST_OK;
                end
            end
            OP_CLOSE_SOCKET:
            begin
                if (live_sock)
                begin
                    slot_busy[idx] = 1'b0;
                    rp.status = ST_OK;
                end
            end
            OP_GET_SOCKET:
            begin
                if (live_sock)
                begin
                    rp.handle = slot_hnd[idx];
                    rp.status = ST_OK;
                end
            end
            OP_EXISTS:
            begin
                if (in_range && slot_busy[idx])
                    rp.status = ST_OK;
            end
            default:
            begin
            end
        endcase
        return rp;
    endfunction

    task automatic push_request(logic [2:0] op, logic [7:0] s, logic [2:0] nd, logic [31:0] h);
        request_queue.push_back('{opcode: op, slot: s, node: nd, handle: h});
    endtask

    // open_pct and close_pct steer the table toward full or empty
    function automatic request_t random_request(int open_pct, int close_pct);
        request_t rq;
        int       r;
        int       sel;
        r = $urandom_range(99);
        sel = $urandom_range(99);
        if (r < open_pct)
            rq.opcode = $urandom_range(1) ? OP_INSTALL_SOCKET : OP_OPEN_FILE;
        else if (r < open_pct + close_pct)
            rq.opcode = $urandom_range(1) ? OP_CLOSE_SOCKET : OP_CLOSE_FILE;
        else if (sel < 45)
            rq.opcode = OP_GET_SOCKET;
        else if (sel < 90)
            rq.opcode = OP_EXISTS;
        else
            rq.opcode = $urandom_range(1) ? OP_RESERVED_7 : OP_RESERVED_6;
        sel = $urandom_range(99);
        if (sel < 80)
            rq.slot = 8'($urandom_range(SLOTS - 1));
        else if (sel < 90)
            rq.slot = 8'($urandom_range(255, SLOTS));
        else
            rq.slot = 8'($urandom_range(255));
        rq.node = 3'($urandom_range(7));
        rq.handle = $urandom;
        // a zero-handle socket can never be closed, so keep them scarce
        if (rq.opcode == OP_INSTALL_SOCKET && zero_handles_left > 0 && $urandom_range(99) == 0)
        begin
            rq.handle = 32'd0;
            zero_handles_left--;
        end
        return rq;
    endfunction

    // driver
    always @(posedge clk)
    begin : drive
        request_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_beat)
                expected_replies.push_back(apply_request('{opcode: opcode, slot: slot_in,
                                                           node: node_index,
                                                           handle: socket_handle}));
            if (!in_valid || in_beat)
            begin
                if (request_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    nxt = request_queue.pop_front();
                    in_valid <= 1'b1;
                    opcode <= nxt.opcode;
                    slot_in <= nxt.slot;
                    node_index <= nxt.node;
                    socket_handle <= nxt.handle;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and result-side stall
    always @(posedge clk)
    begin : collect
        reply_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_beat)
            begin
                replies_seen++;
                if (expected_replies.size() == 0)
                begin
                    $error("result beat with no request pending: status %0d slot %0d handle %h",
                           status, slot_out, handle_out);
                    errors++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errors++;
                    end
                    if (slot_out !== want.slot)
                    begin
                        $error("slot_out: expected %0d, got %0d", want.slot, slot_out);
                        errors++;
                    end
                    if (handle_out !== want.handle)
                    begin
                        $error("handle_out: expected %h, got %h", want.handle, handle_out);
                        errors++;
                    end
                end
            end
            // one long hold-off so the block backs up and stalls its input
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && replies_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog: cycles with work pending but no beat on either side
    always @(posedge clk)
    begin
        if (in_beat || out_beat || (request_queue.size() == 0 && !in_valid &&
                                    expected_replies.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        // empty table, bad descriptors, reserved opcodes
        push_request(OP_EXISTS, 8'd0, 3'd0, 32'd0);
        push_request(OP_GET_SOCKET, 8'd0, 3'd0, 32'd0);
        push_request(OP_RESERVED_6, 8'd0, 3'd7, 32'hFFFF_FFFF);
        push_request(OP_RESERVED_7, 8'd255, 3'd0, 32'd0);
        push_request(OP_EXISTS, 8'd255, 3'd0, 32'd0);
        push_request(OP_CLOSE_SOCKET, 8'd16, 3'd0, 32'd0);
        // one file, one live socket, one zero-handle socket
        push_request(OP_OPEN_FILE, 8'd0, 3'd7, 32'hFFFF_FFFF);
        push_request(OP_INSTALL_SOCKET, 8'd0, 3'd0, 32'hFFFF_FFFF);
        push_request(OP_INSTALL_SOCKET, 8'd0, 3'd0, 32'd0);
        push_request(OP_GET_SOCKET, 8'd1, 3'd0, 32'd0);
        push_request(OP_GET_SOCKET, 8'd2, 3'd0, 32'd0);
        push_request(OP_CLOSE_SOCKET, 8'd2, 3'd0, 32'd0);
        push_request(OP_EXISTS, 8'd2, 3'd0, 32'd0);
        push_request(OP_CLOSE_FILE, 8'd1, 3'd0, 32'd0);
        push_request(OP_CLOSE_SOCKET, 8'd0, 3'd0, 32'd0);
        // fill every slot, then one open too many
        for (int i = 3; i < SLOTS; i++)
            push_request((i % 2) ? OP_INSTALL_SOCKET : OP_OPEN_FILE, 8'd0, 3'(i),
                         32'h1 << i);
        push_request(OP_OPEN_FILE, 8'd0, 3'd5, 32'd0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++)
        begin
            @(negedge clk);
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin sender_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            for (int b = 0; b < 6; b++)
                for (int k = 0; k < BATCH_LEN; k++)
                    case (b % 3)
                        0: request_queue.push_back(random_request(70, 15));
                        1: request_queue.push_back(random_request(10, 70));
                        default: request_queue.push_back(random_request(35, 35));
                    endcase
            while (request_queue.size() > 0)
                @(negedge clk);
        end

        while (request_queue.size() > 0 || in_valid || expected_replies.size() > 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/lfht_pkg.sv
rtl/core/lfht_ram.sv
rtl/core/lfht_ctrl.sv
rtl/core/lfht_dp.sv
rtl/core/lowest_free_handle_table_unit.sv
rtl/core/lfht_checker.sv
dv/testbench.sv
